/* hw/rtl/lpfs_pkg.sv */
// Shared types and constants for the LED panel frame store and scan driver.
// No dependencies; used by lpfs_remap and led_panel_frame_remap_and_scan.
`default_nettype none
package lpfs_pkg;

	localparam int HALF_WIDTH_DEF  = 112;
	localparam int TILE_ROWS_DEF   = 5;
	localparam int PANEL_ROWS      = 10;
	localparam int OUT_CHANNELS    = 50;

	// widest bank address (2*256 entries) and widest channel group (8 tile rows)
	localparam int ADDR_W_MAX = 9;
	localparam int GROUP_W    = 7;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SHIFT = 1'b1;

	// timing step within one pixel: which colour bit goes out
	localparam logic [1:0] PH_BIT2 = 2'd0;
	localparam logic [1:0] PH_BIT1 = 2'd1;
	localparam logic [1:0] PH_BIT0 = 2'd2;

	// row lines: bit0=A, bit1=B, bit2=C, bit3=D
	localparam logic [3:0] ROW_A = 4'h1;
	localparam logic [3:0] ROW_B = 4'h2;
	localparam logic [3:0] ROW_C = 4'h4;
	localparam logic [3:0] ROW_D = 4'h8;

	typedef struct packed {
		logic                  valid;
		logic [GROUP_W-1:0]    group;
		logic [ADDR_W_MAX-1:0] addr;
	} wr_req_t;

endpackage
`default_nettype wire

/* hw/rtl/lpfs_remap.sv */
// Pixel write remap: screen (x, y) to channel bank and offset in that bank.
// Depends on lpfs_pkg.
`default_nettype none
module lpfs_remap #(
	parameter int HALF_WIDTH = lpfs_pkg::HALF_WIDTH_DEF,
	parameter int TILE_ROWS  = lpfs_pkg::TILE_ROWS_DEF
) (
	input  wire logic [7:0]       pixel_x,
	input  wire logic [5:0]       pixel_y,
	output lpfs_pkg::wr_req_t     wr
);

	localparam int AW     = $clog2(2 * HALF_WIDTH);
	localparam int CHANS  = TILE_ROWS * lpfs_pkg::PANEL_ROWS;
	localparam int NBANK  = (CHANS < lpfs_pkg::OUT_CHANNELS) ? CHANS : lpfs_pkg::OUT_CHANNELS;
	localparam logic [9:0] SW      = 10'(2 * HALF_WIDTH);
	localparam logic [9:0] HW10    = 10'(HALF_WIDTH);
	localparam logic [6:0] SH      = 7'(CHANS);
	localparam logic [AW-1:0] HWA  = AW'(HALF_WIDTH);
	localparam logic [lpfs_pkg::GROUP_W-1:0] NB = lpfs_pkg::GROUP_W'(NBANK);

	logic [9:0] xe;
	logic [9:0] prod;
	logic [2:0] q;
	logic [5:0] q10;
	logic [3:0] r;
	logic [2:0] half;
	logic       right;
	logic       on_screen;
	logic [9:0] col;
	logic [lpfs_pkg::GROUP_W-1:0] group;
	logic [AW-1:0] addr;

	always_comb begin
		xe    = {2'b00, pixel_x};
		// y/10 for y < 64 as (y*13) >> 7
		prod  = 10'(pixel_y) * 10'd13;
		q     = prod[9:7];
		q10   = 6'(q) * 6'd10;
		r     = 4'(pixel_y - q10);
		half  = r[3:1];
		right = (xe >= HW10);
		on_screen = (xe < SW) && ({1'b0, pixel_y} < SH);
		if (right) begin
			group = lpfs_pkg::GROUP_W'(q10) + 7'd4 - lpfs_pkg::GROUP_W'(half);
			col   = SW - 10'd1 - xe;
		end else begin
			group = lpfs_pkg::GROUP_W'(q10) + lpfs_pkg::GROUP_W'(half) + 7'd5;
			col   = xe;
		end
		addr = (pixel_y[0] ? HWA : '0) + col[AW-1:0];
		wr.valid = on_screen && (group < NB);
		wr.group = group;
		wr.addr  = lpfs_pkg::ADDR_W_MAX'(addr);
	end

endmodule
`default_nettype wire

/* hw/rtl/lpfs_bank.sv */
// One channel bank of the frame store: simple dual-port RAM, registered read.
// No package dependency.
`default_nettype none
module lpfs_bank #(
	parameter int DEPTH = 224,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [2:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [2:0]         rdata
);

	logic [2:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/led_panel_frame_remap_and_scan.sv */
// LED panel frame store and scan driver (1/2 scan, one RAM bank per channel).
// A shift request passes the decode register, the bank read register and the output
// register in that order; a stall holds all of them.
// Throughput: one request per cycle while req_stall is low; each bank has its own
// read and write port. Reset: async, active low; then a clearing pass zeroes all
// 2*HALF_WIDTH addresses of every bank, during which req_stall is held high.
`default_nettype none
module led_panel_frame_remap_and_scan #(
	parameter int HALF_WIDTH = lpfs_pkg::HALF_WIDTH_DEF,
	parameter int TILE_ROWS  = lpfs_pkg::TILE_ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        cmd,
	input  wire logic [7:0]  pixel_x,
	input  wire logic [5:0]  pixel_y,
	input  wire logic [2:0]  pixel_color,
	input  wire logic        scan_line,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [49:0]      channel_bits,
	output logic [3:0]       row_address,
	output logic             last_of_line
);

	localparam int DEPTH = 2 * HALF_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(HALF_WIDTH);
	localparam int CHANS = TILE_ROWS * lpfs_pkg::PANEL_ROWS;
	localparam int NBANK = (CHANS < lpfs_pkg::OUT_CHANNELS) ? CHANS : lpfs_pkg::OUT_CHANNELS;
	localparam logic [AW-1:0] HWA      = AW'(HALF_WIDTH);
	localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] LAST_COL = CW'(HALF_WIDTH - 1);

	// ---------------------------------------------------------------
	// Clearing pass: one address per cycle across all banks at once.
	// ---------------------------------------------------------------
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADR) begin
				clr_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Handshake. The whole pipe moves when the output register is free
	// or being drained; otherwise every stage holds.
	// ---------------------------------------------------------------
	logic adv;
	logic accept;
	logic rsp_valid_q;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = clr_q || !adv;
	assign accept    = req_valid && !req_stall;

	// ---------------------------------------------------------------
	// Step counter, kept as pixel column and colour phase so that the
	// step/3 and step%3 of the scan order need no divider.
	// Runs free across shift requests, whatever the scan line.
	// ---------------------------------------------------------------
	logic [1:0]    phase_q;
	logic [CW-1:0] col_q;
	logic          step_last;

	assign step_last = (col_q == LAST_COL) && (phase_q == lpfs_pkg::PH_BIT0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpfs_pkg::PH_BIT2;
			col_q   <= '0;
		end else if (accept && cmd == lpfs_pkg::CMD_SHIFT) begin
			if (phase_q == lpfs_pkg::PH_BIT0) begin
				phase_q <= lpfs_pkg::PH_BIT2;
				col_q   <= (col_q == LAST_COL) ? '0 : col_q + 1'b1;
			end else begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: decoded request.
	// ---------------------------------------------------------------
	lpfs_pkg::wr_req_t wr_dec;

	lpfs_remap #(
		.HALF_WIDTH (HALF_WIDTH),
		.TILE_ROWS  (TILE_ROWS)
	) u_remap (
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.wr      (wr_dec)
	);

	logic              v_s1;
	logic              cmd_s1;
	lpfs_pkg::wr_req_t wr_s1;
	logic [2:0]        color_s1;
	logic [AW-1:0]     raddr_s1;
	logic [1:0]        phase_s1;
	logic              last_s1;
	logic [3:0]        row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			cmd_s1   <= cmd;
			wr_s1    <= wr_dec;
			color_s1 <= pixel_color;
			// scan line 1 reads the upper half of each bank
			raddr_s1 <= (scan_line ? HWA : '0) + AW'(col_q);
			phase_s1 <= phase_q;
			last_s1  <= step_last;
			// panel address is line+1 with A and B swapped: line 0 -> B, line 1 -> A
			row_s1   <= scan_line ? lpfs_pkg::ROW_A : lpfs_pkg::ROW_B;
		end
	end

	// ---------------------------------------------------------------
	// Banks: writes and reads both happen at the stage-1 edge, in order,
	// so a shift after a write always sees the new pixel.
	// ---------------------------------------------------------------
	logic [2:0]    rdata [NBANK];
	logic [AW-1:0] waddr;
	logic [2:0]    wdata;
	logic          wr_go;
	logic          rd_go;

	assign waddr = clr_q ? clr_addr_q : wr_s1.addr[AW-1:0];
	assign wdata = clr_q ? 3'b000 : color_s1;
	assign wr_go = adv && v_s1 && (cmd_s1 == lpfs_pkg::CMD_WRITE) && wr_s1.valid;
	assign rd_go = adv && v_s1 && (cmd_s1 == lpfs_pkg::CMD_SHIFT);

	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		logic we;
		assign we = clr_q || (wr_go && wr_s1.group == lpfs_pkg::GROUP_W'(b));

		lpfs_bank #(
			.DEPTH (DEPTH),
			.AW    (AW)
		) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wdata),
			.re    (rd_go),
			.raddr (raddr_s1),
			.rdata (rdata[b])
		);
	end

	// ---------------------------------------------------------------
	// Stage 2: bank data is valid; pick the colour bit per channel.
	// ---------------------------------------------------------------
	logic       v_s2;
	logic [1:0] phase_s2;
	logic       last_s2;
	logic [3:0] row_s2;
	logic [49:0] bits_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= rd_go;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			phase_s2 <= phase_s1;
			last_s2  <= last_s1;
			row_s2   <= row_s1;
		end
	end

	always_comb begin
		bits_s2 = '0;
		for (int b = 0; b < NBANK; b++) begin
			unique case (phase_s2)
				lpfs_pkg::PH_BIT2: bits_s2[b] = rdata[b][2];
				lpfs_pkg::PH_BIT1: bits_s2[b] = rdata[b][1];
				default:           bits_s2[b] = rdata[b][0];
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Output register.
	// ---------------------------------------------------------------
	logic [49:0] channel_bits_q;
	logic [3:0]  row_address_q;
	logic        last_of_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			channel_bits_q <= bits_s2;
			row_address_q  <= row_s2;
			last_of_line_q <= last_s2;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign channel_bits = channel_bits_q;
	assign row_address  = row_address_q;
	assign last_of_line = last_of_line_q;

endmodule
`default_nettype wire

/* tb/sv/led_panel_frame_remap_and_scan_test.sv */
// Self-checking testbench for led_panel_frame_remap_and_scan: pixel writes and scan shifts.
// Depends on lpfs_pkg and the block itself; a built-in frame store model predicts each scan step.
module led_panel_frame_remap_and_scan_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lpfs_pkg::*;

	// panel geometry at the default build of the block
	localparam int HW          = HALF_WIDTH_DEF;
	localparam int SCREEN_W    = 2 * HW;
	localparam int SCREEN_H    = TILE_ROWS_DEF * PANEL_ROWS;
	localparam int CHANNELS    = SCREEN_H;
	localparam int STORE_DEPTH = CHANNELS * SCREEN_W;
	localparam int STEPS       = 3 * HW;

	localparam int RANDOM_ITEMS = 1830;
	localparam int IDLE_LIMIT   = 4000;  // covers the clearing pass and the long hold-off
	localparam int DRAIN_CYCLES = 20;    // leave generous slack
	localparam int HOLD_AT      = 700;   // request count at which the receiver holds off
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [49:0] bits;
		logic [3:0]  row;
		logic        last;
	} scan_result_t;

	// one request as the sender offers it; typed rows carry their own expected result
	typedef struct packed {
		logic         cmd;
		logic [7:0]   x;
		logic [5:0]   y;
		logic [2:0]   color;
		logic         line;
		bit           typed;
		scan_result_t want;
	} stim_t;

	typedef enum int {STALL_NONE, STALL_SPARSE, STALL_ALTERNATE, STALL_HEAVY} stall_mode_t;

	localparam scan_result_t NO_RESULT = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        cmd = CMD_WRITE;
	logic [7:0]  pixel_x = '0;
	logic [5:0]  pixel_y = '0;
	logic [2:0]  pixel_color = '0;
	logic        scan_line = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [49:0] channel_bits;
	logic [3:0]  row_address;
	logic        last_of_line;

	// side-band copy of the typed expectation, held alongside the payload
	logic         drv_typed = 1'b0;
	scan_result_t drv_want = '0;

	led_panel_frame_remap_and_scan dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.scan_line    (scan_line),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.channel_bits (channel_bits),
		.row_address  (row_address),
		.last_of_line (last_of_line)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ---------------------------------------------------------------
	// Frame store model: remapped pixel memory plus the free-running
	// timing step counter.
	// ---------------------------------------------------------------
	logic [2:0]   frame_mem [STORE_DEPTH];
	int unsigned  scan_step;
	scan_result_t scan_results_due [$];

	int unsigned req_count   = 0;
	int unsigned idle_cycles = 0;
	int unsigned mismatches  = 0;
	int          burst_left  = 0;

	initial begin
		foreach (frame_mem[i])
			frame_mem[i] = '0;
		scan_step = 0;
	end

	// Applies one accepted request to the model. A write stores its pixel at the
	// remapped place and yields nothing; a shift yields the channel bits of the
	// current step, with its row address and last flag, and advances the step counter.
	function automatic bit remap_or_shift(input stim_t s, output scan_result_t r);
		int unsigned grp, col, addr, pix, bitpos;
		logic [3:0]  lineaddr;
		r = NO_RESULT;
		if (s.cmd == CMD_WRITE) begin
			// off-screen writes are dropped
			if (s.x < SCREEN_W && s.y < SCREEN_H) begin
				if (s.x < HW) begin
					grp = s.y / PANEL_ROWS * PANEL_ROWS + (s.y % PANEL_ROWS) / 2 + PANEL_ROWS / 2;
					col = s.x;
				end else begin
					// right half: rows fold the other way and the column is mirrored
					grp = s.y / PANEL_ROWS * PANEL_ROWS + (PANEL_ROWS / 2 - 1)
						- (s.y % PANEL_ROWS) / 2;
					col = SCREEN_W - 1 - s.x;
				end
				addr = grp * SCREEN_W + (s.y % 2) * HW + col;
				if (addr < STORE_DEPTH)
					frame_mem[addr] = s.color;
			end
			return 1'b0;
		end
		pix    = scan_step / 3 + s.line * HW;
		bitpos = 2 - scan_step % 3;  // colour bits leave msb first
		for (int ch = 0; ch < CHANNELS && ch < OUT_CHANNELS; ch++) begin
			addr = ch * SCREEN_W + pix;
			if (addr < STORE_DEPTH && frame_mem[addr][bitpos])
				r.bits[ch] = 1'b1;
		end
		// panel address is line+1 with A and B swapped on the connector
		lineaddr = 4'(s.line) + 4'd1;
		r.row = (lineaddr[1] ? ROW_A : 4'h0) | (lineaddr[0] ? ROW_B : 4'h0)
			| (lineaddr[2] ? ROW_C : 4'h0) | (lineaddr[3] ? ROW_D : 4'h0);
		r.last = (scan_step == STEPS - 1);
		// the counter runs free across scan line changes
		scan_step = (scan_step + 1 >= STEPS) ? 0 : scan_step + 1;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Monitor: both channels sampled at the rising edge, before the block's
	// own updates land, so every read sees the pre-edge values.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		stim_t        seen;
		scan_result_t predicted;
		scan_result_t want;
		bit           req_taken;
		bit           rsp_taken;
		if (arst_n) begin
			rsp_taken = rsp_valid && !rsp_stall;
			req_taken = req_valid && !req_stall;

			if (rsp_taken) begin
				if (scan_results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result: bits %h row %h last %b",
							channel_bits, row_address, last_of_line);
				end else begin
					want = scan_results_due.pop_front();
					if (channel_bits !== want.bits || row_address !== want.row
						|| last_of_line !== want.last) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"mismatch: bits exp %h got %h, ",
								"row exp %h got %h, last exp %b got %b"},
								want.bits, channel_bits, want.row, row_address,
								want.last, last_of_line);
					end
				end
			end

			if (req_taken) begin
				req_count++;
				seen = '{cmd, pixel_x, pixel_y, pixel_color, scan_line, drv_typed, drv_want};
				if (remap_or_shift(seen, predicted))
					scan_results_due.push_back(drv_typed ? drv_want : predicted);
			end

			idle_cycles = (req_taken || rsp_taken) ? 0 : idle_cycles + 1;
		end
	end

	// watchdog: too long with neither channel moving
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("timeout after %0d idle cycles", idle_cycles);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------
	// Receiver: stall pattern changes every segment; once, a long hold-off
	// lets the block back up and stall its request side.
	// ---------------------------------------------------------------
	initial begin
		stall_mode_t mode;
		bit          hold_done;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
			repeat ($urandom_range(10, 150)) begin
				if (!hold_done && req_count >= HOLD_AT) begin
					rsp_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					STALL_NONE:      rsp_stall <= 1'b0;
					STALL_SPARSE:    rsp_stall <= ($urandom_range(0, 3) == 0);
					STALL_ALTERNATE: rsp_stall <= ~rsp_stall;
					default:         rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------

	// Offers one request, with a random gap whenever a burst runs out, and
	// returns at the edge where it is taken.
	task automatic offer_request(input stim_t s);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// now and then a long gap-free stretch
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 30);
		end
		burst_left--;
		req_valid   <= 1'b1;
		cmd         <= s.cmd;
		pixel_x     <= s.x;
		pixel_y     <= s.y;
		pixel_color <= s.color;
		scan_line   <= s.line;
		drv_typed   <= s.typed;
		drv_want    <= s.want;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// drop valid and hold off until every expected scan result is back
	task automatic wait_for_results();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (scan_results_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		stim_t       directed_table [$];
		stim_t       s;
		logic        line_run;
		logic [5:0]  y;
		int unsigned col;
		int unsigned pick;

		// Directed part. Typed rows: the first two shifts right after reset,
		// where only the two writes at the top corners can light anything.
		directed_table = '{
			'{CMD_WRITE, 8'd0,   6'd0,  3'd7, 1'b0, 1'b0, NO_RESULT},  // left corner
			'{CMD_WRITE, 8'd223, 6'd0,  3'd2, 1'b0, 1'b0, NO_RESULT},  // right corner
			'{CMD_SHIFT, 8'd0,   6'd0,  3'd0, 1'b0, 1'b1, '{50'h20, ROW_B, 1'b0}},
			'{CMD_SHIFT, 8'd0,   6'd0,  3'd0, 1'b1, 1'b1, '{50'h0,  ROW_A, 1'b0}},
			'{CMD_WRITE, 8'd223, 6'd49, 3'd5, 1'b0, 1'b0, NO_RESULT},  // bottom right
			'{CMD_WRITE, 8'd111, 6'd49, 3'd6, 1'b0, 1'b0, NO_RESULT},  // left half edge
			'{CMD_WRITE, 8'd112, 6'd10, 3'd3, 1'b0, 1'b0, NO_RESULT},  // right half edge
			'{CMD_WRITE, 8'd0,   6'd1,  3'd7, 1'b0, 1'b0, NO_RESULT},
			'{CMD_WRITE, 8'd255, 6'd0,  3'd7, 1'b0, 1'b0, NO_RESULT},  // off screen, x
			'{CMD_WRITE, 8'd0,   6'd63, 3'd7, 1'b0, 1'b0, NO_RESULT},  // off screen, y
			'{CMD_WRITE, 8'd224, 6'd50, 3'd7, 1'b0, 1'b0, NO_RESULT},  // just past both
			'{CMD_WRITE, 8'd128, 6'd32, 3'd1, 1'b0, 1'b0, NO_RESULT},
			'{CMD_SHIFT, 8'd0,   6'd0,  3'd0, 1'b1, 1'b0, NO_RESULT},
			'{CMD_SHIFT, 8'd0,   6'd0,  3'd0, 1'b1, 1'b0, NO_RESULT},
			'{CMD_SHIFT, 8'd0,   6'd0,  3'd0, 1'b0, 1'b0, NO_RESULT},  // line change
			'{CMD_WRITE, 8'd1,   6'd25, 3'd4, 1'b0, 1'b0, NO_RESULT},
			'{CMD_WRITE, 8'd222, 6'd24, 3'd7, 1'b0, 1'b0, NO_RESULT},
			'{CMD_SHIFT, 8'd0,   6'd0,  3'd0, 1'b0, 1'b0, NO_RESULT},
			'{CMD_SHIFT, 8'd0,   6'd0,  3'd0, 1'b1, 1'b0, NO_RESULT},
			'{CMD_SHIFT, 8'd0,   6'd0,  3'd0, 1'b0, 1'b0, NO_RESULT}
		};

		// reset once; the block then clears its store with req_stall high
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_table[i])
			offer_request(directed_table[i]);
		wait_for_results();

		// Random part: mostly shifts and writes aimed at the columns about to
		// be scanned, so lit pixels actually show up; the rest is scattered
		// writes, some of them off screen.
		line_run = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			s = '0;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				s.cmd = CMD_SHIFT;
				if ($urandom_range(0, 9) == 0)
					line_run = ~line_run;
				s.line = line_run;
			end else begin
				s.cmd   = CMD_WRITE;
				s.color = 3'($urandom_range(0, 7));
				if (pick < 85) begin
					col     = (scan_step / 3 + $urandom_range(0, 3)) % HW;
					y       = 6'($urandom_range(0, SCREEN_H - 1));
					y[0]    = line_run;  // row parity picks the scan line
					s.y     = y;
					s.x     = 8'($urandom_range(0, 1) ? col : SCREEN_W - 1 - col);
				end else if (pick < 95) begin
					s.x = 8'($urandom_range(0, SCREEN_W - 1));
					s.y = 6'($urandom_range(0, SCREEN_H - 1));
				end else begin
					s.x = 8'($urandom_range(0, 255));
					s.y = 6'($urandom_range(0, 63));
				end
			end
			// halfway through, let every outstanding result drain
			if (n == RANDOM_ITEMS / 2)
				wait_for_results();
			offer_request(s);
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && scan_results_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (scan_results_due.size() != 0)
				$display("%0d results never arrived", scan_results_due.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/lpfs_pkg.sv
hw/rtl/lpfs_remap.sv
hw/rtl/lpfs_bank.sv
hw/rtl/led_panel_frame_remap_and_scan.sv
tb/sv/led_panel_frame_remap_and_scan_test.sv
